FILE: rtl/cft_pkg.sv
// Shared types, constants and register codes for the CSV field tokenizer.
`timescale 1ns / 1ps

package cft_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int MaxRowsDef   = 1024;
  localparam int MaxColsDef   = 64;
  localparam int CellBytesDef = 256;

  // Internal counter widths, set by the register widths.
  localparam int LineW  = 11;
  localparam int FieldW = 7;

  // Result queue sizing.
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // Special byte values.
  localparam logic [7:0] QuoteByte   = 8'd34;
  localparam logic [7:0] NewlineByte = 8'd10;
  localparam logic [7:0] ZeroByte    = 8'd0;

  // Configuration register indexes.
  localparam logic [1:0] CfgSeparator = 2'd0;
  localparam logic [1:0] CfgRowLimit  = 2'd1;
  localparam logic [1:0] CfgColLimit  = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]        SeparatorRst = 8'd44;
  localparam logic [LineW-1:0]  RowLimitRst  = 11'd1024;
  localparam logic [FieldW-1:0] ColLimitRst  = 7'd26;

  // Input and result kind codes.
  localparam logic InData       = 1'b0;
  localparam logic InEnd        = 1'b1;
  localparam logic OutContent   = 1'b0;
  localparam logic OutCellDone  = 1'b1;

  // Input word.
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic       out_kind;
    logic [9:0] row_index;
    logic [5:0] col_index;
    logic [7:0] char_offset;
    logic [7:0] char_value;
    logic       last_of_run;
  } out_word_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0]        separator;
    logic [LineW-1:0]  row_limit;
    logic [FieldW-1:0] col_limit;
  } cft_cfg_t;

  // Up to two results pushed into the queue in one cycle.
  typedef struct packed {
    logic      push0;
    logic      push1;
    out_word_t word0;
    out_word_t word1;
  } cft_push_t;

endpackage

FILE: rtl/cft_parse.sv
// Input register and per-byte tokenizer state update.
`timescale 1ns / 1ps

module cft_parse #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 64,
  parameter int CELL_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cft_pkg::in_word_t in_data,
  input  cft_pkg::cft_cfg_t cfg,
  input  logic              room,
  output cft_pkg::cft_push_t push
);
  import cft_pkg::*;

  localparam int LenW    = $clog2(CELL_BYTES);
  localparam int LineMax = (1 << LineW) - 1;
  localparam int FieldMax = (1 << FieldW) - 1;
  localparam int RowCap  = (MAX_ROWS > LineMax) ? LineMax : MAX_ROWS;
  localparam int ColCap  = (MAX_COLS > FieldMax) ? FieldMax : MAX_COLS;
  localparam logic [LineW-1:0]  RowCapV = LineW'(RowCap);
  localparam logic [FieldW-1:0] ColCapV = FieldW'(ColCap);
  localparam logic [LenW-1:0]   LenMax  = LenW'(CELL_BYTES - 1);

  // Input register.
  logic     in_valid_r;
  in_word_t in_word_r;

  // Tokenizer state.
  logic [LineW-1:0]  line_r, line_nxt;
  logic [FieldW-1:0] field_r, field_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic              start_r, start_nxt;
  logic              quoted_r, quoted_nxt;
  logic              qpend_r, qpend_nxt;
  logic              skip_r, skip_nxt;

  logic              go;
  logic [LineW-1:0]  rlim;
  logic [FieldW-1:0] clim;
  logic              rows_ok;
  logic              active;
  logic [7:0]        b;
  logic [7:0]        sep;
  logic              len_room0;
  logic              len_room1;
  logic [LenW-1:0]   len_p1;
  logic [LenW+7:0]   len_ext;
  logic [LenW+7:0]   len_p1_ext;
  logic              e0_v;
  logic              e0_kind;
  logic [7:0]        e0_val;
  logic              e1_v;

  assign go       = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  // Effective limits are the registers capped at the sizing parameters.
  assign rlim    = (cfg.row_limit < RowCapV) ? cfg.row_limit : RowCapV;
  assign clim    = (cfg.col_limit < ColCapV) ? cfg.col_limit : ColCapV;
  assign rows_ok = line_r < rlim;
  assign active  = rows_ok && !skip_r && !start_r;
  assign b       = in_word_r.byte_value;
  assign sep     = cfg.separator;

  // Room for one or two more content bytes in the cell.
  assign len_room0  = len_r < LenMax;
  assign len_room1  = ({1'b0, len_r} + 1'b1) < {1'b0, LenMax};
  assign len_p1     = len_r + 1'b1;
  assign len_ext    = {8'd0, len_r};
  assign len_p1_ext = {8'd0, len_p1};

  // Decode one byte into state changes and up to two results.
  always_comb begin
    line_nxt   = line_r;
    field_nxt  = field_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    quoted_nxt = quoted_r;
    qpend_nxt  = qpend_r;
    skip_nxt   = skip_r;
    e0_v       = 1'b0;
    e0_kind    = OutContent;
    e0_val     = 8'd0;
    e1_v       = 1'b0;

    if (in_word_r.kind == InEnd) begin
      // End of input closes the open cell and returns to the reset state.
      e0_v       = active && (len_r != '0);
      e0_kind    = OutCellDone;
      line_nxt   = '0;
      field_nxt  = '0;
      skip_nxt   = 1'b0;
      len_nxt    = '0;
      start_nxt  = 1'b1;
      quoted_nxt = 1'b0;
      qpend_nxt  = 1'b0;
    end else if (b == NewlineByte) begin
      // Newline closes the cell and starts the next line.
      e0_v       = active && (len_r != '0);
      e0_kind    = OutCellDone;
      if (rows_ok) begin
        line_nxt = line_r + 1'b1;
      end
      field_nxt  = '0;
      skip_nxt   = 1'b0;
      len_nxt    = '0;
      start_nxt  = 1'b1;
      quoted_nxt = 1'b0;
      qpend_nxt  = 1'b0;
    end else if (!rows_ok || skip_r) begin
      // Byte is ignored.
    end else if (start_r) begin
      if ((field_r >= clim) || (b == ZeroByte)) begin
        skip_nxt = 1'b1;
      end else if (b == QuoteByte) begin
        quoted_nxt = 1'b1;
        start_nxt  = 1'b0;
      end else if (b == sep) begin
        field_nxt  = field_r + 1'b1;
        len_nxt    = '0;
        start_nxt  = 1'b1;
        quoted_nxt = 1'b0;
        qpend_nxt  = 1'b0;
      end else begin
        start_nxt  = 1'b0;
        quoted_nxt = 1'b0;
        e0_v       = len_room0;
        e0_val     = b;
        len_nxt    = len_r + LenW'(len_room0);
      end
    end else if (quoted_r && qpend_r) begin
      if (b == sep) begin
        e0_v       = len_r != '0;
        e0_kind    = OutCellDone;
        field_nxt  = field_r + 1'b1;
        len_nxt    = '0;
        start_nxt  = 1'b1;
        quoted_nxt = 1'b0;
        qpend_nxt  = 1'b0;
      end else if (b == ZeroByte) begin
        e0_v     = len_r != '0;
        e0_kind  = OutCellDone;
        skip_nxt = 1'b1;
      end else if (b == QuoteByte) begin
        // The held quote becomes content and this quote is held instead.
        e0_v    = len_room0;
        e0_val  = QuoteByte;
        len_nxt = len_r + LenW'(len_room0);
      end else begin
        // The held quote and this byte both become content.
        qpend_nxt = 1'b0;
        e0_v      = len_room0;
        e0_val    = QuoteByte;
        e1_v      = len_room1;
        len_nxt   = len_r + LenW'(len_room0) + LenW'(len_room1);
      end
    end else if (quoted_r) begin
      if (b == ZeroByte) begin
        e0_v     = len_r != '0;
        e0_kind  = OutCellDone;
        skip_nxt = 1'b1;
      end else if (b == QuoteByte) begin
        qpend_nxt = 1'b1;
      end else begin
        e0_v    = len_room0;
        e0_val  = b;
        len_nxt = len_r + LenW'(len_room0);
      end
    end else begin
      if (b == ZeroByte) begin
        e0_v     = len_r != '0;
        e0_kind  = OutCellDone;
        skip_nxt = 1'b1;
      end else if (b == sep) begin
        e0_v       = len_r != '0;
        e0_kind    = OutCellDone;
        field_nxt  = field_r + 1'b1;
        len_nxt    = '0;
        start_nxt  = 1'b1;
        quoted_nxt = 1'b0;
        qpend_nxt  = 1'b0;
      end else begin
        e0_v    = len_room0;
        e0_val  = b;
        len_nxt = len_r + LenW'(len_room0);
      end
    end
  end

  // Build the result words; both carry the current row and column.
  always_comb begin
    push.push0             = go && e0_v;
    push.push1             = go && e1_v;
    push.word0.out_kind    = e0_kind;
    push.word0.row_index   = line_r[9:0];
    push.word0.col_index   = field_r[5:0];
    push.word0.char_offset = len_ext[7:0];
    push.word0.char_value  = e0_val;
    push.word0.last_of_run = !e1_v;
    push.word1.out_kind    = OutContent;
    push.word1.row_index   = line_r[9:0];
    push.word1.col_index   = field_r[5:0];
    push.word1.char_offset = len_p1_ext[7:0];
    push.word1.char_value  = b;
    push.word1.last_of_run = 1'b1;
  end

  // Input register and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      line_r     <= '0;
      field_r    <= '0;
      len_r      <= '0;
      start_r    <= 1'b1;
      quoted_r   <= 1'b0;
      qpend_r    <= 1'b0;
      skip_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (go) begin
        line_r   <= line_nxt;
        field_r  <= field_nxt;
        len_r    <= len_nxt;
        start_r  <= start_nxt;
        quoted_r <= quoted_nxt;
        qpend_r  <= qpend_nxt;
        skip_r   <= skip_nxt;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_data;
    end
  end

endmodule

FILE: rtl/cft_out_queue.sv
// Small result queue that takes up to two words a cycle and hands out one unless the output stalls.
`timescale 1ns / 1ps

module cft_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cft_pkg::cft_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output cft_pkg::out_word_t out_data
);
  import cft_pkg::*;

  out_word_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic [QPtrW-1:0] wr_ptr_p1;
  logic             pop;

  // Room for a full two-word push, independent of this cycle's read.
  assign room      = count_r <= QCntW'(QDepth - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push.push0) + QPtrW'(push.push1);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(pop);
    count_nxt  = count_r + QCntW'(push.push0) + QCntW'(push.push1) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes; the second word goes in the slot after the first.
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.word0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.word1;
    end
  end

endmodule

FILE: rtl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: configuration registers, parser and result queue.
// An accepted input word is held in the input register; its results pass through the
// result queue. Throughput: one input word per cycle while the queue has room. A word
// that causes two results uses the single result port once for each, so the input
// stalls while three or more words wait in the four-entry result queue.
// Reset (rst_n low, synchronous) clears the queue, the parser state and restores the
// configuration registers to separator 44, row limit 1024 and column limit 26.
`timescale 1ns / 1ps

module csv_field_tokenizer #(
  parameter int MAX_ROWS   = cft_pkg::MaxRowsDef,
  parameter int MAX_COLS   = cft_pkg::MaxColsDef,
  parameter int CELL_BYTES = cft_pkg::CellBytesDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cft_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cft_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [cft_pkg::LineW-1:0]   cfg_data
);
  import cft_pkg::*;

  cft_cfg_t  cfg_r;
  cft_push_t push;
  logic      room;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator <= SeparatorRst;
      cfg_r.row_limit <= RowLimitRst;
      cfg_r.col_limit <= ColLimitRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgSeparator: begin
          cfg_r.separator <= cfg_data[7:0];
        end
        CfgRowLimit: begin
          cfg_r.row_limit <= cfg_data;
        end
        CfgColLimit: begin
          cfg_r.col_limit <= cfg_data[FieldW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Byte decoder and state.
  cft_parse #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .CELL_BYTES (CELL_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .room     (room),
    .push     (push)
  );

  // Result queue.
  cft_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
